### design/pibc_pkg.sv
// Shared types and constants of the PID controller with integral band.
`default_nettype none

package pibc_pkg;

  localparam int unsigned DataW = 32;   // width of one value field
  localparam int unsigned IntW  = 48;   // integral accumulator width
  localparam int unsigned NumW  = 64;   // divider dividend width
  localparam int unsigned DenW  = 32;   // divider divisor width
  localparam int unsigned AccW  = 80;   // one gain product, full width
  localparam int unsigned TotW  = 66;   // sum of three floored products
  localparam int unsigned InW   = 128;  // input tdata width
  localparam int unsigned OutW  = 40;   // output tdata width
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DenW-1:0] MsPerS = 32'd1000;
  // ceil(2^36 / 1000): exact quotient by 1000 for dividends below 2^26
  localparam logic [26:0] RecipMs = 27'd68719477;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE  = 3'd0,
    CFG_KP    = 3'd1,
    CFG_KI    = 3'd2,
    CFG_KD    = 3'd3,
    CFG_INNER = 3'd4,
    CFG_OUTER = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ERR = 2'd0,
    MODE_VEL = 2'd1,
    MODE_FF  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_e;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_SETUP = 15'b000000000000010,
    ST_BANDS = 15'b000000000000100,
    ST_RPREP = 15'b000000000001000,
    ST_RGO   = 15'b000000000010000,
    ST_RDIV  = 15'b000000000100000,
    ST_RFIN  = 15'b000000001000000,
    ST_IPREP = 15'b000000010000000,
    ST_IGO   = 15'b000000100000000,
    ST_IDIV  = 15'b000001000000000,
    ST_IUPD  = 15'b000010000000000,
    ST_MUL   = 15'b000100000000000,
    ST_TERM  = 15'b001000000000000,
    ST_DONE  = 15'b010000000000000,
    ST_SPARE = 15'b100000000000000
  } state_e;

  typedef struct packed {
    logic       load;
    logic       setup;
    logic       bands;
    logic       rprep;
    logic       iprep;
    logic       div_start;
    logic       kdiv_start;
    logic       rfin;
    logic       iupd;
    logic       mul_step;
    logic       term_add;
    logic       out_load;
    logic [1:0] chunk;
    term_e      term;
  } cmd_t;

  typedef struct packed {
    logic dms_zero;
    logic in_band;
    logic div_done;
    logic kdiv_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### design/pid_integral_band_controller_top.sv
// Top level of the PID controller with integral band: stream ports, controller and datapath.
`default_nettype none

// One input transfer carries a set point, a reading, a velocity feed and a
// millisecond timestamp; one output transfer returns the saturated drive
// value and a saturation flag. Values are signed Q24.8, gains signed Q16.16.
// Items are handled one at a time: an item runs the rate divide only when time
// has passed since the previous item, and the integral increment divide only
// when the error magnitude lies inside the integration band; it may also wait
// while the previous result still sits unread in the output register.
// The rate divide runs on a restoring divider that yields one quotient bit per
// cycle over a 64-bit dividend; the integral increment is divided by 1000 one
// 16-bit digit per cycle with a reciprocal multiply. The three gain products
// share one 17x32 multiplier; each product sums three 16-bit operand chunks
// in turn and is then folded into the total. The result sits in an output
// register, so the next item is taken while it waits. Configuration writes
// are registered and are meant for idle periods.
module pid_integral_band_controller_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // target, measured, velocity_feed, now_ms
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // drive, saturated, zero pad
);

  pibc_pkg::cmd_t cmd;
  pibc_pkg::sts_t sts;

  // sequence each item: setup, divides, integral update, products, result
  pibc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold configuration, controller state and all arithmetic
  pibc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // an accepted transfer always starts the setup step next
  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> cmd.setup)
    else $error("accepted item did not enter setup");

  // never overwrite a result that is still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  // a new result shows only after a load
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a load");

endmodule

`default_nettype wire

### design/pibc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module pibc_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pibc_pkg::NumW-1:0]     num_i,
  input  wire logic [pibc_pkg::DenW-1:0]     den_i,
  output logic      [pibc_pkg::NumW-1:0]     quo_o,
  output logic                               done_o
);

  localparam int unsigned CntW = $clog2(pibc_pkg::NumW);

  logic [pibc_pkg::DenW-1:0] rem_q, rem_d, den_q;
  logic [pibc_pkg::NumW-1:0] quo_q, quo_d;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q, done_q;
  logic [pibc_pkg::DenW:0]   shifted;
  logic [pibc_pkg::DenW+1:0] trial;
  logic                      fits;

  always_comb begin
    shifted = {rem_q, quo_q[pibc_pkg::NumW-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    fits    = ~trial[pibc_pkg::DenW+1];
    rem_d   = fits ? trial[pibc_pkg::DenW-1:0] : shifted[pibc_pkg::DenW-1:0];
    quo_d   = {quo_q[pibc_pkg::NumW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(pibc_pkg::NumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### design/pibc_dpath.sv
// Datapath: configuration, state, divider operands, shared gain multiplier, output register.
`default_nettype none

module pibc_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pibc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                 cfg_data_i,
  input  wire logic [pibc_pkg::InW-1:0]    in_data_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [pibc_pkg::OutW-1:0]        out_data_o,
  input  wire pibc_pkg::cmd_t              cmd_i,
  output pibc_pkg::sts_t                   sts_o
);

  // configuration
  logic [1:0]         mode_q;
  logic signed [31:0] kp_q, ki_q, kd_q;
  logic [30:0]        inner_q, outer_q;

  // persistent state
  logic [31:0]        prev_time_q;
  logic signed [31:0] prev_meas_q;
  logic signed [pibc_pkg::IntW-1:0] integ_q;

  // per item
  logic signed [31:0] tgt_q, meas_q, vfeed_q;
  logic [31:0]        now_q, dms_q;
  logic signed [32:0] diff_q, err_q;
  logic [32:0]        mag_q, dabs_q;
  logic               in_band_q, clr_q, sat_q;
  logic signed [pibc_pkg::IntW-1:0] rate_q;
  logic [pibc_pkg::NumW-1:0] div_num_q;
  logic [pibc_pkg::DenW-1:0] div_den_q;
  logic [pibc_pkg::NumW-1:0] div_quo;
  logic               div_done;
  logic [63:0]        kn_q, kq_q;
  logic [9:0]         krem_q;
  logic [1:0]         kcnt_q;
  logic               kbusy_q, kdone_q;
  logic signed [pibc_pkg::AccW-1:0] tacc_q;
  logic signed [pibc_pkg::TotW-1:0] total_q;
  logic               out_valid_q;
  logic [31:0]        drive_q;
  logic               out_sat_q;

  // combinational
  logic [42:0]        rnum;
  logic [62:0]        inum;
  logic [25:0]        kx;
  logic [52:0]        kprod;
  logic [15:0]        kdig;
  logic [9:0]         kback, krem_d;
  logic signed [pibc_pkg::IntW-1:0] rate_abs, rate_sgn, rate_d;
  logic signed [54:0] inc_abs, inc;
  logic signed [55:0] isum;
  logic               ovf_hi, ovf_lo;
  logic signed [pibc_pkg::IntW-1:0] op_a;
  logic signed [31:0] gain;
  logic signed [16:0] digit;
  logic signed [48:0] part;
  logic signed [pibc_pkg::AccW-1:0] part_x, part_sh;
  logic signed [pibc_pkg::TotW-1:0] term_v;
  logic               fits32;
  logic [31:0]        drive_d;

  pibc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pibc_pkg::MODE_ERR;
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      inner_q <= 31'd7680;
      outer_q <= 31'd38400;
    end else if (cfg_we_i) begin
      unique case (pibc_pkg::cfg_idx_e'(cfg_idx_i))
        pibc_pkg::CFG_MODE:  mode_q  <= cfg_data_i[1:0];
        pibc_pkg::CFG_KP:    kp_q    <= $signed(cfg_data_i);
        pibc_pkg::CFG_KI:    ki_q    <= $signed(cfg_data_i);
        pibc_pkg::CFG_KD:    kd_q    <= $signed(cfg_data_i);
        pibc_pkg::CFG_INNER: inner_q <= cfg_data_i[30:0];
        pibc_pkg::CFG_OUTER: outer_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rnum     = 43'(dabs_q) * 43'(pibc_pkg::MsPerS);
    inum     = 63'(mag_q[30:0]) * 63'(dms_q);

    // one base-2^16 digit of the divide by 1000: remainder and next digit
    kx       = {krem_q, kn_q[63:48]};
    kprod    = 53'(kx) * 53'(pibc_pkg::RecipMs);
    kdig     = kprod[51:36];
    kback    = 10'(kdig * 16'(pibc_pkg::MsPerS));
    krem_d   = kx[9:0] - kback;

    rate_abs = $signed({1'b0, div_quo[46:0]});
    rate_sgn = diff_q[32] ? -rate_abs : rate_abs;
    rate_d   = (mode_q == pibc_pkg::MODE_VEL) ? rate_sgn + pibc_pkg::IntW'(vfeed_q)
                                              : rate_sgn;
    inc_abs  = $signed({1'b0, kq_q[53:0]});
    inc      = err_q[32] ? -inc_abs : inc_abs;
    isum     = 56'(integ_q) + 56'(inc);
    ovf_hi   = ~isum[55] & (isum[54:47] != 8'h00);
    ovf_lo   = isum[55] & (isum[54:47] != 8'hFF);

    unique case (cmd_i.term)
      pibc_pkg::TERM_P: begin
        op_a = (mode_q == pibc_pkg::MODE_FF) ? pibc_pkg::IntW'(tgt_q)
                                             : pibc_pkg::IntW'(err_q);
        gain = kp_q;
      end
      pibc_pkg::TERM_I: begin
        op_a = integ_q;
        gain = ki_q;
      end
      pibc_pkg::TERM_D: begin
        op_a = rate_q;
        gain = kd_q;
      end
      default: begin
        op_a = '0;
        gain = '0;
      end
    endcase

    unique case (cmd_i.chunk)
      2'd0:    digit = $signed({1'b0, op_a[15:0]});
      2'd1:    digit = $signed({1'b0, op_a[31:16]});
      2'd2:    digit = $signed({op_a[47], op_a[47:32]});
      default: digit = '0;
    endcase
    part    = 49'(digit) * 49'(gain);
    part_x  = pibc_pkg::AccW'(part);
    part_sh = part_x <<< {cmd_i.chunk, 4'b0000};

    // floor of the term's product over 2^16
    term_v  = pibc_pkg::TotW'($signed(tacc_q[pibc_pkg::AccW-1:16]));

    fits32  = (total_q[pibc_pkg::TotW-1:31] == {(pibc_pkg::TotW-31){total_q[31]}});
    drive_d = fits32 ? total_q[31:0]
                     : (total_q[pibc_pkg::TotW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  end

  // digit counter of the divide by 1000: four digits, done flagged in the cycle after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbusy_q <= 1'b0;
      kdone_q <= 1'b0;
      kcnt_q  <= '0;
    end else begin
      kdone_q <= 1'b0;
      if (cmd_i.kdiv_start) begin
        kbusy_q <= 1'b1;
        kcnt_q  <= 2'd3;
      end else if (kbusy_q) begin
        kcnt_q <= kcnt_q - 2'd1;
        if (kcnt_q == 2'd0) begin
          kbusy_q <= 1'b0;
          kdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.iprep) begin
      kn_q <= 64'(inum);
    end
    if (cmd_i.kdiv_start) begin
      krem_q <= '0;
    end else if (kbusy_q) begin
      kn_q   <= {kn_q[47:0], 16'h0000};
      krem_q <= krem_d;
      kq_q   <= {kq_q[47:0], kdig};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      prev_meas_q <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.setup) begin
        prev_time_q <= now_q;
        prev_meas_q <= meas_q;
      end
      if (cmd_i.iupd) begin
        if (clr_q) begin
          integ_q <= '0;
        end else if (in_band_q) begin
          if (ovf_hi) begin
            integ_q <= {1'b0, {(pibc_pkg::IntW-1){1'b1}}};
          end else if (ovf_lo) begin
            integ_q <= {1'b1, {(pibc_pkg::IntW-1){1'b0}}};
          end else begin
            integ_q <= isum[pibc_pkg::IntW-1:0];
          end
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q   <= $signed(in_data_i[31:0]);
      meas_q  <= $signed(in_data_i[63:32]);
      vfeed_q <= $signed(in_data_i[95:64]);
      now_q   <= in_data_i[127:96];
      sat_q   <= 1'b0;
    end
    if (cmd_i.setup) begin
      dms_q  <= now_q - prev_time_q;
      diff_q <= 33'(meas_q) - 33'(prev_meas_q);
      err_q  <= 33'(tgt_q) - 33'(meas_q);
    end
    if (cmd_i.bands) begin
      mag_q     <= err_q[32] ? $unsigned(-err_q) : $unsigned(err_q);
      dabs_q    <= diff_q[32] ? $unsigned(-diff_q) : $unsigned(diff_q);
      in_band_q <= 1'b0;
      clr_q     <= 1'b0;
    end
    if (cmd_i.rprep) begin
      // band flags from the registered magnitude
      in_band_q <= (mag_q > {2'b00, inner_q}) && (mag_q < {2'b00, outer_q});
      clr_q     <= mag_q > {2'b00, outer_q};
      div_num_q <= pibc_pkg::NumW'(rnum);
      div_den_q <= dms_q;
    end
    if (cmd_i.rfin) begin
      rate_q <= (dms_q == '0) ? '0 : rate_d;
    end
    if (cmd_i.iupd) begin
      if (in_band_q && (ovf_hi || ovf_lo)) begin
        sat_q <= 1'b1;
      end
      tacc_q  <= '0;
      total_q <= '0;
    end
    if (cmd_i.mul_step) begin
      tacc_q <= tacc_q + part_sh;
    end
    if (cmd_i.term_add) begin
      tacc_q  <= '0;
      total_q <= (cmd_i.term == pibc_pkg::TERM_D) ? total_q - term_v : total_q + term_v;
    end
    if (cmd_i.out_load) begin
      drive_q   <= drive_d;
      out_sat_q <= sat_q | ~fits32;
    end
  end

  assign sts_o.dms_zero  = (dms_q == '0);
  assign sts_o.in_band   = in_band_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.kdiv_done = kdone_q;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {7'b0000000, out_sat_q, drive_q};

endmodule

`default_nettype wire

### design/pibc_ctrl.sv
// Controller state machine sequencing one item through the datapath.
`default_nettype none

module pibc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire pibc_pkg::sts_t sts_i,
  output pibc_pkg::cmd_t      cmd_o
);

  pibc_pkg::state_e state_q, state_d;
  logic [1:0]       chunk_q, chunk_d;
  pibc_pkg::term_e  term_q, term_d;

  always_comb begin
    state_d = state_q;
    chunk_d = chunk_q;
    term_d  = term_q;
    cmd_o   = '0;
    cmd_o.chunk = chunk_q;
    cmd_o.term  = term_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      pibc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pibc_pkg::ST_SETUP;
        end
      end
      pibc_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = pibc_pkg::ST_BANDS;
      end
      pibc_pkg::ST_BANDS: begin
        cmd_o.bands = 1'b1;
        state_d     = pibc_pkg::ST_RPREP;
      end
      pibc_pkg::ST_RPREP: begin
        cmd_o.rprep = 1'b1;
        state_d     = sts_i.dms_zero ? pibc_pkg::ST_RFIN : pibc_pkg::ST_RGO;
      end
      pibc_pkg::ST_RGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = pibc_pkg::ST_RDIV;
      end
      pibc_pkg::ST_RDIV: begin
        if (sts_i.div_done) begin
          state_d = pibc_pkg::ST_RFIN;
        end
      end
      pibc_pkg::ST_RFIN: begin
        cmd_o.rfin = 1'b1;
        state_d    = sts_i.in_band ? pibc_pkg::ST_IPREP : pibc_pkg::ST_IUPD;
      end
      pibc_pkg::ST_IPREP: begin
        cmd_o.iprep = 1'b1;
        state_d     = pibc_pkg::ST_IGO;
      end
      pibc_pkg::ST_IGO: begin
        cmd_o.kdiv_start = 1'b1;
        state_d          = pibc_pkg::ST_IDIV;
      end
      pibc_pkg::ST_IDIV: begin
        if (sts_i.kdiv_done) begin
          state_d = pibc_pkg::ST_IUPD;
        end
      end
      pibc_pkg::ST_IUPD: begin
        cmd_o.iupd = 1'b1;
        chunk_d    = 2'd0;
        term_d     = pibc_pkg::TERM_P;
        state_d    = pibc_pkg::ST_MUL;
      end
      pibc_pkg::ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        chunk_d        = chunk_q + 2'd1;
        if (chunk_q == 2'd2) begin
          state_d = pibc_pkg::ST_TERM;
        end
      end
      pibc_pkg::ST_TERM: begin
        cmd_o.term_add = 1'b1;
        chunk_d        = 2'd0;
        unique case (term_q)
          pibc_pkg::TERM_P: begin
            term_d  = pibc_pkg::TERM_I;
            state_d = pibc_pkg::ST_MUL;
          end
          pibc_pkg::TERM_I: begin
            term_d  = pibc_pkg::TERM_D;
            state_d = pibc_pkg::ST_MUL;
          end
          default: begin
            state_d = pibc_pkg::ST_DONE;
          end
        endcase
      end
      pibc_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = pibc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pibc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pibc_pkg::ST_IDLE;
      chunk_q <= 2'd0;
      term_q  <= pibc_pkg::TERM_P;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
      term_q  <= term_d;
    end
  end

endmodule

`default_nettype wire
